// ===== hdl/mm3_pkg.sv =====
// Shared types and mixing constants for the MurmurHash3 x86_32 stream core.
package mm3_pkg;

   localparam logic [31:0] MIX_C1  = 32'hCC9E2D51;
   localparam logic [31:0] MIX_C2  = 32'h1B873593;
   localparam logic [31:0] MIX_ADD = 32'hE6546B64;
   localparam logic [31:0] FIN_M1  = 32'h85EBCA6B;
   localparam logic [31:0] FIN_M2  = 32'hC2B2AE35;

   localparam logic [2:0] NBYTES_NONE = 3'd0;
   localparam logic [2:0] NBYTES_FULL = 3'd4;

   // One classified item as it travels from the front to the back.
   typedef struct packed {
      logic [31:0] word;     // data with bytes above the valid ones cleared
      logic [2:0]  nbytes;   // saturated byte count, 0 to 4
      logic        ends;     // item closes the message
   } entry_type;

endpackage

// ===== hdl/murmur3_32_hash_stream_core.sv =====
// Top level of the MurmurHash3 x86_32 stream core: front end, item queue, hash engine.
// The engine takes one item at a time and pops the next only from ST_IDLE: a body word
// steps through K1, K2 and MIX; a closing word goes on to F1, F2 and OUT; a bare
// end-of-message marker goes straight to F1, F2 and OUT. The shared 32x32 multiplier
// serializes these steps; OUT holds while the result register is still occupied.
// Reset: synchronous, active high; clears the queue, engine state and seed to zero.
module murmur3_32_hash_stream_core
   import mm3_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // input item channel
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_hash,
   // seed register
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0] seed_ff, seed_in;
   logic        q_push, q_pop, q_full, q_empty;
   entry_type   q_in_entry, q_out_entry;

   // Seed is sampled by the engine when a message opens, so a write lands
   // on the next message.
   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Classify each item: saturate the byte count, mask tail bytes, drop
   // empty items that do not close a message.
   mm3_front u_front (
      .req_push        (req_push),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .q_full          (q_full),
      .req_full        (req_full),
      .q_push          (q_push),
      .q_entry         (q_in_entry)
   );

   // Decouple the front end from the multi-cycle engine.
   mm3_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .pop_entry  (q_out_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   // Mix blocks into the running hash and finalize at message end; the
   // result register lets the engine move on while a hash waits.
   mm3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .q_empty   (q_empty),
      .q_entry   (q_out_entry),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_hash  (rsp_hash)
   );

endmodule

// ===== hdl/mm3_front.sv =====
// Front end: accepts items, saturates the byte count, masks the tail, drops empty fillers.
module mm3_front
   import mm3_pkg::*;
(
   input  logic        req_push,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last,
   input  logic        q_full,
   output logic        req_full,
   output logic        q_push,
   output entry_type   q_entry
);

   logic [2:0]  nbytes;
   logic [31:0] mask;

   always_comb begin
      nbytes = (req_valid_bytes > NBYTES_FULL) ? NBYTES_FULL : req_valid_bytes;
      case (nbytes)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         3'd4:    mask = 32'hFFFF_FFFF;
         default: mask = 32'h0000_0000;
      endcase
   end

   assign req_full       = q_full;
   // drop an empty item that does not close the message
   assign q_push         = req_push && !q_full && ((nbytes != NBYTES_NONE) || req_last);
   assign q_entry.word   = req_data_word & mask;
   assign q_entry.nbytes = nbytes;
   assign q_entry.ends   = (nbytes != NBYTES_FULL) || req_last;

endmodule

// ===== hdl/mm3_fifo.sv =====
// Short queue of classified items between the front end and the hash engine.
module mm3_fifo
   import mm3_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      full,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count above depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");
`endif

endmodule

// ===== hdl/mm3_back.sv =====
// Hash engine: block mixing, length xor, fmix32 finalizer on one shared multiplier.
module mm3_back
   import mm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] seed,
   input  logic        q_empty,
   input  entry_type   q_entry,
   output logic        q_pop,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_hash
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_K1   = 7'b0000010,
      ST_K2   = 7'b0000100,
      ST_MIX  = 7'b0001000,
      ST_F1   = 7'b0010000,
      ST_F2   = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic        open_ff, open_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] word_ff, word_in;
   logic        full_ff, full_in;
   logic        ends_ff, ends_in;
   logic [31:0] out_ff, out_in;

   logic [31:0] mul_a, mul_b, mul_out;
   logic [31:0] len_x, fin_x, mix_t, mix_r, fin_out;
   logic        out_free;

   assign len_x   = hash_ff ^ count_ff;
   assign fin_x   = prod_ff ^ (prod_ff >> 13);
   assign fin_out = prod_ff ^ (prod_ff >> 16);
   assign mix_t   = hash_ff ^ prod_ff;
   assign mix_r   = {mix_t[18:0], mix_t[31:19]};
   assign out_free = !out_valid_ff || rsp_pop;

   // shared multiplier, operands chosen by step
   always_comb begin
      case (state_ff)
         ST_K1: begin
            mul_a = word_ff;
            mul_b = MIX_C1;
         end
         ST_K2: begin
            mul_a = {prod_ff[16:0], prod_ff[31:17]};
            mul_b = MIX_C2;
         end
         ST_F1: begin
            mul_a = len_x ^ (len_x >> 16);
            mul_b = FIN_M1;
         end
         ST_F2: begin
            mul_a = fin_x;
            mul_b = FIN_M2;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_out = mul_a * mul_b;
   end

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      hash_in      = hash_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      word_in      = word_ff;
      full_in      = full_ff;
      ends_in      = ends_ff;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               word_in  = q_entry.word;
               full_in  = (q_entry.nbytes == NBYTES_FULL);
               ends_in  = q_entry.ends;
               open_in  = 1'b1;
               // load seed and clear the count at message start
               hash_in  = open_ff ? hash_ff : seed;
               count_in = (open_ff ? count_ff : 32'd0) + 32'(q_entry.nbytes);
               state_in = (q_entry.nbytes == NBYTES_NONE) ? ST_F1 : ST_K1;
            end
         end
         ST_K1: begin
            prod_in  = mul_out;
            state_in = ST_K2;
         end
         ST_K2: begin
            prod_in  = mul_out;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            hash_in  = full_ff ? ((mix_r << 2) + mix_r + MIX_ADD) : mix_t;
            state_in = ends_ff ? ST_F1 : ST_IDLE;
         end
         ST_F1: begin
            prod_in  = mul_out;
            state_in = ST_F2;
         end
         ST_F2: begin
            prod_in  = mul_out;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register frees up
            if (out_free) begin
               out_in       = fin_out;
               out_valid_in = 1'b1;
               open_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         open_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff  <= hash_in;
      count_ff <= count_in;
      prod_ff  <= prod_in;
      word_ff  <= word_in;
      full_ff  <= full_in;
      ends_ff  <= ends_in;
      out_ff   <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_hash  = out_ff;

endmodule

// ===== verif/tb_murmur3_32_hash_stream_core.sv =====
// Self-checking testbench for the streamed MurmurHash3 x86_32 core.
`timescale 1ns / 100ps

module tb_murmur3_32_hash_stream_core;
   import mm3_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 5;
   // Margin for the engine to finish after the last expected hash is back.
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_QUOTA  = 250;
   localparam int HOLD_CYCLES  = 400;
   // Window with no random idling on either side.
   localparam int CALM_FROM    = 6000;
   localparam int CALM_TO      = 10000;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
   } word_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_valid_bytes = '0;
   logic        req_last = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_hash;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   word_item_type word_backlog[$];
   logic [31:0]   hashes_due[$];

   // Predictor state: our own copy of the seed and the running message.
   logic [31:0] seed_value = '0;
   logic [31:0] acc_hash = '0;
   logic [31:0] acc_bytes = '0;
   logic        acc_open = 1'b0;

   int          cycle_count = 0;
   int          error_count = 0;
   int          hashes_seen = 0;
   int          hold_left = 0;
   int          last_hold_mark = -1;
   int          phase_items = 0;

   murmur3_32_hash_stream_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_hash        (rsp_hash),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Hash predictor
   // ---------------------------------------------------------------------

   // Scramble one 32-bit block: multiply, rotate left 15, multiply.
   function automatic logic [31:0] scramble_block(input logic [31:0] k);
      k = k * MIX_C1;
      k = {k[16:0], k[31:17]};
      k = k * MIX_C2;
      return k;
   endfunction

   // Avalanche the final state (fmix32).
   function automatic logic [31:0] avalanche(input logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * FIN_M1;
      h = h ^ (h >> 13);
      h = h * FIN_M2;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // Fold one accepted word into the running message. Return 1 and the
   // finished hash when the word closes the message.
   function automatic bit absorb_word(input word_item_type it, output logic [31:0] digest);
      logic [2:0]  n;
      logic [31:0] h;
      logic        closes;
      n = (it.nbytes > NBYTES_FULL) ? NBYTES_FULL : it.nbytes;
      digest = '0;
      // An empty word without the end mark is dropped outright.
      if (n == NBYTES_NONE && !it.last)
         return 1'b0;
      // Open a message: load the seed as it stands now.
      if (!acc_open) begin
         acc_hash  = seed_value;
         acc_bytes = '0;
         acc_open  = 1'b1;
      end
      h = acc_hash;
      if (n == NBYTES_FULL) begin
         h = h ^ scramble_block(it.word);
         h = {h[18:0], h[31:19]};
         h = h * 32'd5 + MIX_ADD;
         closes = it.last;
      end else if (n != NBYTES_NONE) begin
         // Tail: keep only the valid low bytes, no rotate or add.
         h = h ^ scramble_block(it.word & ~(32'hFFFF_FFFF << {n, 3'b000}));
         closes = 1'b1;
      end else begin
         closes = 1'b1;
      end
      acc_bytes = acc_bytes + 32'(n);
      acc_hash  = h;
      if (!closes)
         return 1'b0;
      digest    = avalanche(h ^ acc_bytes);
      acc_hash  = seed_value;
      acc_bytes = '0;
      acc_open  = 1'b0;
      return 1'b1;
   endfunction

   // Roll for a random idle cycle, about 8 in 100, none in the calm window.
   function automatic bit idle_roll();
      if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
         return 1'b0;
      return $urandom_range(99) < 8;
   endfunction

   // ---------------------------------------------------------------------
   // Cycle counter and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("murmur3_32_hash_stream_core verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: predict on acceptance, then offer the next queued word
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      word_item_type nxt;
      logic [31:0]   digest;
      if (!reset) begin
         if (req_push && !req_full) begin
            nxt = '{word: req_data_word, nbytes: req_valid_bytes, last: req_last};
            if (absorb_word(nxt, digest))
               hashes_due.push_back(digest);
         end
         // Hold the offered word while the core is full; otherwise advance.
         if (!req_push || !req_full) begin
            if (word_backlog.size() != 0 && !idle_roll()) begin
               nxt = word_backlog.pop_front();
               req_data_word   <= nxt.word;
               req_valid_bytes <= nxt.nbytes;
               req_last        <= nxt.last;
               req_push        <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each popped hash against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (hashes_due.size() == 0) begin
               $error("hash: expected none, actual %08h", rsp_hash);
               error_count++;
            end else begin
               want = hashes_due.pop_front();
               if (rsp_hash !== want) begin
                  $error("hash: expected %08h, actual %08h", want, rsp_hash);
                  error_count++;
               end
            end
            hashes_seen++;
         end
         // Twice in the run, stop popping for a long stretch so the core
         // backs up and pushes back on the sender.
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else if ((hashes_seen == 30 || hashes_seen == 200) &&
                      last_hold_mark != hashes_seen) begin
            last_hold_mark <= hashes_seen;
            hold_left      <= HOLD_CYCLES;
            rsp_pop        <= 1'b0;
         end else begin
            rsp_pop <= !idle_roll();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Queue one word; count it unless the core just drops it.
   task automatic add_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
      word_backlog.push_back('{word: w, nbytes: nb, last: lst});
      if (!(nb == NBYTES_NONE && !lst))
         phase_items++;
   endtask

   // Wait until every word is taken and every hash is back, then let the
   // engine finish any word that produces no hash.
   task automatic wait_for_idle();
      @(negedge clock);
      while (word_backlog.size() != 0 || req_push)
         @(negedge clock);
      while (hashes_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      seed_value   = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed messages with random content, some raw noise.
   task automatic queue_random_traffic(input int quota);
      int body;
      int ending;
      phase_items = 0;
      while (phase_items < quota) begin
         if ($urandom_range(99) < 15) begin
            // Noise: any field values at all.
            repeat ($urandom_range(1, 4))
               add_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)));
         end else begin
            body = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(5);
            repeat (body) begin
               if ($urandom_range(19) == 0)
                  add_word($urandom, NBYTES_NONE, 1'b0);
               add_word($urandom,
                        ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : NBYTES_FULL,
                        1'b0);
            end
            ending = $urandom_range(3);
            case (ending)
               0, 1: add_word($urandom, 3'($urandom_range(1, 3)), 1'($urandom_range(1)));
               2: add_word($urandom, 3'($urandom_range(7, 4)), 1'b1);
               default: add_word($urandom, NBYTES_NONE, 1'b1);
            endcase
         end
      end
   endtask

   initial begin
      logic [31:0] seeds[6];
      seeds = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001,
                $urandom, $urandom};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset seed of zero.
      @(negedge clock);
      add_word(32'h0000_0000, NBYTES_NONE, 1'b1);   // empty message
      add_word(32'hFFFF_FFFF, NBYTES_FULL, 1'b1);   // full word closes
      add_word(32'h0000_0000, NBYTES_FULL, 1'b0);
      add_word(32'hFFFF_FFFF, NBYTES_FULL, 1'b0);
      add_word(32'hA5C3_9E17, 3'd3, 1'b0);          // short word ends regardless
      add_word(32'hFFFF_FFFF, 3'd1, 1'b1);
      add_word(32'hFFFF_FFFF, 3'd2, 1'b0);
      add_word(32'h1234_5678, NBYTES_NONE, 1'b0);   // dropped, no message open
      add_word(32'h0BAD_F00D, NBYTES_FULL, 1'b0);
      add_word(32'hDEAD_BEEF, NBYTES_NONE, 1'b0);   // dropped mid-message
      add_word(32'h0F0F_0F0F, 3'd5, 1'b0);          // counts above four saturate
      add_word(32'hF0F0_F0F0, 3'd6, 1'b0);
      add_word(32'h5555_AAAA, 3'd7, 1'b0);
      add_word(32'hFFFF_FFFF, NBYTES_NONE, 1'b1);   // aligned end
      add_word(32'h8000_0001, 3'd7, 1'b1);
      add_word(32'h0000_0000, 3'd1, 1'b0);
      add_word(32'h0000_0000, 3'd3, 1'b1);
      wait_for_idle();

      // Random traffic under a sweep of seeds, idle between phases.
      foreach (seeds[i]) begin
         write_seed(seeds[i]);
         @(negedge clock);
         add_word(32'h0, NBYTES_NONE, 1'b1);         // empty message per seed
         queue_random_traffic(PHASE_QUOTA);
         wait_for_idle();
      end

      if (error_count == 0) begin
         $display("murmur3_32_hash_stream_core verification clean");
      end else begin
         $display("murmur3_32_hash_stream_core verification failed");
      end
      $finish;
   end

endmodule
